// ----- sv/hpc_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the dual channel hysteresis pulse counter
package hpc_pkg;

  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned SECOND_W  = 8;
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned S_DATA_W  = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 8'd1;

  // reset levels of the thresholds
  localparam logic [SAMPLE_W-1:0] HIGH_THRESHOLD_RESET = 10'd768;
  localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RESET  = 10'd256;

  // item kinds carried in tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // word groups of the read map, index bits [2:1]
  localparam logic [1:0] GRP_SAMPLE = 2'd0;
  localparam logic [1:0] GRP_PULSE  = 2'd1;
  localparam logic [1:0] GRP_RATE   = 2'd2;
  localparam logic [1:0] GRP_PREV   = 2'd3;

  // read code offset and flip applied before the word index is taken
  localparam logic [CODE_W-1:0] CODE_OFFSET = 8'h01;
  localparam logic [CODE_W-1:0] CODE_FLIP   = 8'h01;

  // result word handed from the core to the output register
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] value;
  } res_t;

endpackage

// ----- sv/dual_channel_hysteresis_pulse_counter_unit.sv -----
`timescale 1ns / 1ps
// top level of the dual channel hysteresis pulse counter
//
// Slave stream s_*: one word per converter sample or read request. tuser is
// the kind (0 = sample, 1 = read); tdata carries sample, seconds count and
// read code. Samples alternate between channel 0 and channel 1, starting
// with channel 0 after reset. A sample produces no output word; a read
// produces one 16-bit word on the master stream m_*.
// Config port cfg_*: index 0 = high threshold, 1 = low threshold; always ready.
// Write it only while no word is in flight.
// Throughput: one word per cycle unless the receiver stalls with a result held.
// All state updates at the accepting edge; a read's result appears on m_tdata
// in the cycle after acceptance, from a single output register.
// When the receiver stalls with a result held, s_tready drops until that
// word is taken; it rises again in the same cycle m_tready is seen.
// Reset (rst, synchronous) clears all counters, samples, rates and the
// channel selector and restores thresholds 768 and 256.
module dual_channel_hysteresis_pulse_counter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [hpc_pkg::S_DATA_W-1:0]  s_tdata,   // sample[9:0], second_count[17:10],
                                                   // read_code[25:18], zeros above
  input  logic                          s_tuser,   // operation
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [hpc_pkg::WORD_W-1:0]    m_tdata,   // read_value[15:0]
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hpc_pkg::SAMPLE_W-1:0]  cfg_data
);
  import hpc_pkg::*;

  logic item_we;
  res_t res;

  // take a word unless a result is held and not being taken
  assign s_tready  = !m_tvalid || m_tready;
  assign item_we   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  hpc_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_we      (item_we),
    .operation    (s_tuser),
    .sample       (s_tdata[SAMPLE_W-1:0]),
    .second_count (s_tdata[SAMPLE_W+SECOND_W-1:SAMPLE_W]),
    .read_code    (s_tdata[SAMPLE_W+SECOND_W+CODE_W-1:SAMPLE_W+SECOND_W]),
    .res          (res)
  );

  hpc_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- sv/hpc_core.sv -----
`timescale 1ns / 1ps
// channel state, hysteresis edge detection, rate update and read selection
module hpc_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [hpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hpc_pkg::SAMPLE_W-1:0]  cfg_data,
  input  logic                        item_we,
  input  logic                        operation,
  input  logic [hpc_pkg::SAMPLE_W-1:0]  sample,
  input  logic [hpc_pkg::SECOND_W-1:0]  second_count,
  input  logic [hpc_pkg::CODE_W-1:0]    read_code,
  output hpc_pkg::res_t               res
);
  import hpc_pkg::*;

  logic [SAMPLE_W-1:0] high_threshold;
  logic [SAMPLE_W-1:0] low_threshold;
  logic                channel_select;
  logic [SECOND_W-1:0] last_second;
  logic [WORD_W-1:0]   last_sample    [2];
  logic [WORD_W-1:0]   pulse_count    [2];
  logic [WORD_W-1:0]   edge_rate      [2];
  logic [WORD_W-1:0]   previous_edges [2];
  logic [WORD_W-1:0]   edge_count     [2];

  logic [WORD_W-1:0]   last_sample_next    [2];
  logic [WORD_W-1:0]   pulse_count_next    [2];
  logic [WORD_W-1:0]   edge_rate_next      [2];
  logic [WORD_W-1:0]   previous_edges_next [2];
  logic [WORD_W-1:0]   edge_count_next     [2];
  logic [WORD_W-1:0]   edge_diff           [2];

  logic                sample_we;
  logic                read_we;
  logic                second_changed;
  logic [CODE_W-1:0]   map_code;
  logic [2:0]          word_idx;
  logic                clear_pulse;

  assign sample_we      = item_we && (operation == OP_SAMPLE);
  assign read_we        = item_we && (operation == OP_READ);
  assign second_changed = (second_count != last_second);

  // read map: code minus one, lowest bit flipped, low three bits pick the word
  assign map_code    = (read_code - CODE_OFFSET) ^ CODE_FLIP;
  assign word_idx    = map_code[2:0];
  assign clear_pulse = (map_code[CODE_W-1:2] == '0) && map_code[1];

  // per-channel next state
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      last_sample_next[c]    = last_sample[c];
      edge_count_next[c]     = edge_count[c];
      pulse_count_next[c]    = pulse_count[c];
      edge_rate_next[c]      = edge_rate[c];
      previous_edges_next[c] = previous_edges[c];

      // hysteresis on the selected channel
      if (sample_we && (channel_select == 1'(c))) begin
        last_sample_next[c] = {{(WORD_W-SAMPLE_W){1'b0}}, sample};
        if (!edge_count[c][0]) begin
          if (sample > high_threshold) begin
            edge_count_next[c] = edge_count[c] + 16'd1;
          end
        end else begin
          if (sample < low_threshold) begin
            edge_count_next[c]  = edge_count[c] + 16'd1;
            pulse_count_next[c] = pulse_count[c] + 16'd1;
          end
        end
      end

      // once-per-second rate from the updated edge count
      edge_diff[c] = edge_count_next[c] - previous_edges[c];
      if (sample_we && second_changed) begin
        edge_rate_next[c]      = edge_diff[c] >> 1;
        previous_edges_next[c] = edge_count_next[c];
      end

      // clear on read of a pulse count
      if (read_we && clear_pulse && (word_idx[0] == 1'(c))) begin
        pulse_count_next[c] = '0;
      end
    end
  end

  // selected word for a read
  always_comb begin
    res.valid = read_we;
    case (word_idx[2:1])
      GRP_SAMPLE: res.value = word_idx[0] ? last_sample[1]    : last_sample[0];
      GRP_PULSE:  res.value = word_idx[0] ? pulse_count[1]    : pulse_count[0];
      GRP_RATE:   res.value = word_idx[0] ? edge_rate[1]      : edge_rate[0];
      GRP_PREV:   res.value = word_idx[0] ? previous_edges[1] : previous_edges[0];
      default:    res.value = '0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      high_threshold <= HIGH_THRESHOLD_RESET;
      low_threshold  <= LOW_THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HIGH_THRESHOLD: high_threshold <= cfg_data;
        CFG_LOW_THRESHOLD:  low_threshold  <= cfg_data;
        default: ;
      endcase
    end
  end

  // channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_select <= 1'b0;
      last_second    <= '0;
      for (int c = 0; c < 2; c++) begin
        last_sample[c]    <= '0;
        pulse_count[c]    <= '0;
        edge_rate[c]      <= '0;
        previous_edges[c] <= '0;
        edge_count[c]     <= '0;
      end
    end else begin
      if (sample_we) begin
        channel_select <= ~channel_select;
        last_second    <= second_count;
      end
      for (int c = 0; c < 2; c++) begin
        last_sample[c]    <= last_sample_next[c];
        pulse_count[c]    <= pulse_count_next[c];
        edge_rate[c]      <= edge_rate_next[c];
        previous_edges[c] <= previous_edges_next[c];
        edge_count[c]     <= edge_count_next[c];
      end
    end
  end

endmodule

// ----- sv/hpc_out_reg.sv -----
`timescale 1ns / 1ps
// result register on the master side of the stream
module hpc_out_reg (
  input  logic                       clk,
  input  logic                       rst,
  input  hpc_pkg::res_t              res,
  input  logic                       m_tready,
  output logic                       m_tvalid,
  output logic [hpc_pkg::WORD_W-1:0] m_tdata
);
  import hpc_pkg::*;

  logic              valid;
  logic [WORD_W-1:0] data;

  // valid flag: set on a new word, dropped once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res.valid) begin
      valid <= 1'b1;
    end else if (m_tready) begin
      valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (res.valid) begin
      data <= res.value;
    end
  end

  assign m_tvalid = valid;
  assign m_tdata  = data;

endmodule

// ----- sv/hpc_checker.sv -----
`timescale 1ns / 1ps
// port-level checks for the dual channel hysteresis pulse counter
module hpc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       s_tuser,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [hpc_pkg::WORD_W-1:0] m_tdata
);
  import hpc_pkg::*;

  // no result word right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds its word
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // every accepted read shows a result in the next cycle
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_READ) |=> m_tvalid)
    else $error("read gave no result");

  // a sample never creates a result on an empty output
  a_sample_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_SAMPLE) && !m_tvalid |=> !m_tvalid)
    else $error("sample gave a result");

endmodule

bind dual_channel_hysteresis_pulse_counter_unit hpc_checker u_hpc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- verif/hpc_stream_checker.sv -----
`timescale 1ns / 1ps
// stream checker: tracks counter state from accepted words and checks read results
module hpc_stream_checker
  import hpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_DATA_W-1:0]  s_tdata,   // sample[9:0], second_count[17:10], read_code[25:18]
  input  logic                 s_tuser,   // operation
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [WORD_W-1:0]    m_tdata,   // read_value[15:0]
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_data,
  output int unsigned          words_outstanding,
  output int unsigned          mismatch_count
);

  // input word fields, lowest first at the bottom
  typedef struct packed {
    logic [CODE_W-1:0]   code;
    logic [SECOND_W-1:0] second;
    logic [SAMPLE_W-1:0] level;
  } in_word_t;

  // thresholds as written over the config port
  logic [SAMPLE_W-1:0] hi_level;
  logic [SAMPLE_W-1:0] lo_level;

  // per channel counter state
  logic                chan_sel;
  logic [WORD_W-1:0]   held_sample [2];
  logic [WORD_W-1:0]   pulses      [2];
  logic [WORD_W-1:0]   rate        [2];
  logic [WORD_W-1:0]   prev_edges  [2];
  logic [WORD_W-1:0]   edges       [2];
  logic [SECOND_W-1:0] seen_second;

  // read results still owed by the block, oldest first
  logic [WORD_W-1:0]   read_words_q [$];

  // apply one accepted word to the counter state, queue the word a read returns
  task automatic advance_counters(input logic op, input in_word_t w);
    logic [CODE_W-1:0] m;
    logic [2:0]        idx;
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] diff;
    logic              ch;
    if (op == OP_READ) begin
      m   = (w.code - CODE_OFFSET) ^ CODE_FLIP;
      idx = m[2:0];
      case (idx[2:1])
        GRP_SAMPLE: value = held_sample[idx[0]];
        GRP_PULSE:  value = pulses[idx[0]];
        GRP_RATE:   value = rate[idx[0]];
        default:    value = prev_edges[idx[0]];
      endcase
      read_words_q.push_back(value);
      // only the unmasked pulse codes clear on read
      if (m[CODE_W-1:3] == '0 && idx[2:1] == GRP_PULSE) pulses[idx[0]] = '0;
    end else begin
      ch = chan_sel;
      held_sample[ch] = WORD_W'(w.level);
      // hysteresis: even count waits for high crossing, odd for low crossing
      if (!edges[ch][0]) begin
        if (w.level > hi_level) edges[ch] = edges[ch] + 1'b1;
      end else if (w.level < lo_level) begin
        edges[ch]  = edges[ch] + 1'b1;
        pulses[ch] = pulses[ch] + 1'b1;
      end
      // seconds change: rate update after this sample
      if (w.second != seen_second) begin
        seen_second = w.second;
        for (int c = 0; c < 2; c++) begin
          diff          = edges[c] - prev_edges[c];
          rate[c]       = diff >> 1;
          prev_edges[c] = edges[c];
        end
      end
      chan_sel = ~ch;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      hi_level    = HIGH_THRESHOLD_RESET;
      lo_level    = LOW_THRESHOLD_RESET;
      chan_sel    = 1'b0;
      seen_second = '0;
      for (int c = 0; c < 2; c++) begin
        held_sample[c] = '0;
        pulses[c]      = '0;
        rate[c]        = '0;
        prev_edges[c]  = '0;
        edges[c]       = '0;
      end
      read_words_q.delete();
    end else begin
      // result side: compare with the oldest owed word
      if (m_tvalid && m_tready) begin
        if (read_words_q.size() == 0) begin
          $error("read_value: word with no read pending, actual %0h", m_tdata);
          mismatch_count++;
        end else if (m_tdata !== read_words_q[0]) begin
          $error("read_value mismatch: expected %0h, actual %0h", read_words_q[0], m_tdata);
          mismatch_count++;
          void'(read_words_q.pop_front());
        end else begin
          void'(read_words_q.pop_front());
        end
      end
      // threshold writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HIGH_THRESHOLD: hi_level = cfg_data;
          CFG_LOW_THRESHOLD:  lo_level = cfg_data;
          default: ;
        endcase
      end
      // input side
      if (s_tvalid && s_tready)
        advance_counters(s_tuser, in_word_t'(s_tdata[$bits(in_word_t)-1:0]));
    end
    words_outstanding = read_words_q.size();
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// testbench top: clock, reset, stimulus phases and verdict for the pulse counter
module tb_top;
  import hpc_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned WRAP_SAMPLES    = 40;
  localparam int unsigned BUSY_PCT        = 80;
  localparam int unsigned BOTH_PCT        = 21;
  localparam int unsigned WATCHDOG_LIMIT  = 5000;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata   = '0;   // sample[9:0], second_count[17:10], read_code[25:18]
  logic                 s_tuser   = 1'b0; // operation
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [WORD_W-1:0]    m_tdata;          // read_value[15:0]
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SAMPLE_W-1:0]  cfg_data  = '0;

  int unsigned words_outstanding;
  int unsigned mismatch_count;

  // stimulus knobs
  int unsigned         send_idle_pct  = 0;
  int unsigned         recv_stall_pct = 0;
  int unsigned         thr_high       = 768;
  int unsigned         thr_low        = 256;
  logic [SECOND_W-1:0] cur_sec        = '0;

  dual_channel_hysteresis_pulse_counter_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hpc_stream_checker i_checker (
    .clk               (clk),
    .rst               (rst),
    .s_tvalid          (s_tvalid),
    .s_tready          (s_tready),
    .s_tdata           (s_tdata),
    .s_tuser           (s_tuser),
    .m_tvalid          (m_tvalid),
    .m_tready          (m_tready),
    .m_tdata           (m_tdata),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .words_outstanding (words_outstanding),
    .mismatch_count    (mismatch_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // present one word, with random idle cycles ahead of it, and wait for the handshake
  task automatic send_word(input logic op, input logic [SAMPLE_W-1:0] smp,
                           input logic [SECOND_W-1:0] sec, input logic [CODE_W-1:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'd0, code, sec, smp};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic [SECOND_W-1:0] sec);
    cur_sec = sec;
    send_word(OP_SAMPLE, smp, sec, CODE_W'($urandom_range(255)));
  endtask

  // sample and seconds fields are don't-care on a read, so randomize them
  task automatic send_read(input logic [CODE_W-1:0] code);
    send_word(OP_READ, SAMPLE_W'($urandom_range(1023)), SECOND_W'($urandom_range(255)), code);
  endtask

  // drop valid, wait until every read word is back, then let the pipe settle
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (words_outstanding != 0);
    repeat (2) @(posedge clk);
  endtask

  // write both thresholds back to back, valid held high across the pair
  task automatic write_thresholds(input int unsigned hi, input int unsigned lo);
    thr_high  = hi;
    thr_low   = lo;
    cfg_valid <= 1'b1;
    cfg_index <= CFG_HIGH_THRESHOLD;
    cfg_data  <= SAMPLE_W'(hi);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_LOW_THRESHOLD;
    cfg_data  <= SAMPLE_W'(lo);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly threshold-crossing samples, steady seconds, a quarter reads
  task automatic random_item();
    int unsigned         roll;
    logic [SAMPLE_W-1:0] smp;
    logic [SECOND_W-1:0] sec;
    roll = $urandom_range(99);
    if (roll < 25) begin
      if ($urandom_range(1)) send_read(CODE_W'($urandom_range(8, 1)));
      else send_read(CODE_W'($urandom_range(255)));
    end else begin
      roll = $urandom_range(99);
      if (roll < 10) sec = cur_sec + 1'b1;
      else if (roll < 15) sec = SECOND_W'($urandom_range(255));
      else sec = cur_sec;
      case ($urandom_range(9))
        0, 1, 2: smp = (thr_high < 1023) ? SAMPLE_W'($urandom_range(1023, thr_high + 1))
                                         : SAMPLE_W'(1023);
        3, 4, 5: smp = (thr_low > 0) ? SAMPLE_W'($urandom_range(thr_low - 1, 0)) : '0;
        6:       smp = SAMPLE_W'($urandom_range(thr_high, thr_low));
        7:       smp = $urandom_range(1) ? SAMPLE_W'(1023) : '0;
        default: smp = SAMPLE_W'($urandom_range(1023));
      endcase
      send_sample(smp, sec);
    end
  endtask

  // stall watchdog: cycles with no handshake on any channel
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: reset thresholds, edges at the range ends and at the exact levels
    send_sample(1023, 0);  // ch0 rises
    send_sample(0, 0);     // ch1 even count, no edge
    send_sample(0, 0);     // ch0 falls, pulse
    send_sample(1023, 0);  // ch1 rises
    send_sample(768, 0);   // ch0 equal to high level, no edge
    send_sample(256, 0);   // ch1 equal to low level, no edge
    send_sample(769, 0);   // ch0 rises
    send_sample(255, 0);   // ch1 falls, pulse
    send_sample(1023, 1);  // ch0 no edge, seconds change updates rates
    // every word of the map, pulse codes clear
    for (int code = 1; code <= 8; code++) send_read(CODE_W'(code));
    send_read(3);
    send_read(4);
    send_sample(10, 255);  // ch1 no edge, seconds jump to top
    send_sample(0, 255);   // ch0 falls, pulse
    // masked pulse codes read without clearing, code 0 and top code wrap around
    send_read(12);
    send_read(12);
    send_read(0);
    send_read(255);
    send_read(11);
    drain();

    // every sample toggles its channel's edge count
    write_thresholds(0, 1023);
    send_read(3);
    send_read(4);
    repeat (WRAP_SAMPLES) send_sample(512, cur_sec);
    for (int code = 3; code <= 8; code++) send_read(CODE_W'(code));
    send_sample(512, cur_sec + 1'b1);
    for (int code = 5; code <= 8; code++) send_read(CODE_W'(code));
    drain();

    // random phases over threshold settings and idle patterns
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;        recv_stall_pct = 0;        end
        1: begin send_idle_pct = BUSY_PCT; recv_stall_pct = 0;        end
        2: begin send_idle_pct = 0;        recv_stall_pct = BUSY_PCT; end
        default: begin send_idle_pct = BOTH_PCT; recv_stall_pct = BOTH_PCT; end
      endcase
      case (p)
        0: write_thresholds(0, 1023);
        1: write_thresholds(1023, 0);
        2: write_thresholds(600, 300);
        3: write_thresholds(512, 512);
        5: write_thresholds(1023, 1023);
        6: write_thresholds(0, 0);
        default: write_thresholds($urandom_range(1023), $urandom_range(1023));
      endcase
      repeat (ITEMS_PER_PHASE) random_item();
      drain();
    end

    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
